// ===== rtl/rtre_pkg.sv =====
// Package with shared types and constants for the rigid transform residual error block.
`timescale 1ns / 1ps
`default_nettype none
package rtre_pkg;
  localparam int NUM_COEFS = 12;
  localparam int SUM_WIDTH = 48;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PAIR = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_ROW  = 7'b0000100,
    ST_SQ   = 7'b0001000,
    ST_SQRT = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/rigid_transform_residual_error.sv =====
// Top level of the rigid transform residual error block.
//
// Channel | Direction | tdata fields (low bit up)                          | tuser
// in_     | slave     | op, coef_index, coef_value, src_xyz, ref_xyz        | -   , tlast=last_point
// out_    | master    | out_x, out_y, out_z, residual, mean_error           | mean_valid
//
// A coefficient load is written while the block is idle. A point pair runs nine products
// through one shared multiplier, with the three row sums between, three squares through the
// same multiplier, a square root that settles one result bit per cycle and, on the last
// pair, a restoring division that yields one quotient bit per cycle after its setup.
// Reset is synchronous and active low; it clears coefficients, the sum and the count.
// The input is not ready while a pair is worked on, or while a finished pair waits for
// the output register to free up; a stalled output simply holds its request.
`timescale 1ns / 1ps
`default_nettype none
module rigid_transform_residual_error
  import rtre_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int MAX_POINTS  = 65536
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // op, coef_index[4], coef_value, src_x, src_y, src_z, ref_x, ref_y, ref_z, zero pad
  input  wire logic [((7*COORD_WIDTH+5+7)/8)*8-1:0] in_tdata,
  input  wire logic in_tlast,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // out_x, out_y, out_z, residual, mean_error
  output logic [5*COORD_WIDTH-1:0] out_tdata,
  // mean_valid
  output logic [0:0] out_tuser
);
  localparam int W   = COORD_WIDTH;
  localparam int PW  = 2*W;
  localparam int CW  = $clog2(MAX_POINTS+1);
  localparam int IW  = $clog2(PW+1);
  localparam int SQW = 2*W + 2;
  localparam int RW  = W + 1;

  state_t state_r, state_nxt;
  logic signed [W-1:0] coef_r [NUM_COEFS];
  logic signed [W-1:0] src_r [3];
  logic signed [W-1:0] refp_r [3];
  logic signed [W-1:0] res_r [3];
  logic last_r;
  logic [1:0] row_r, col_r;
  logic signed [PW+2:0] acc_r;
  logic [SQW-1:0] sqs_r;
  logic [SQW-1:0] rem_r;
  logic [W-1:0] root_r;
  logic [IW-1:0] it_r;
  logic [SUM_WIDTH-1:0] sum_r, quo_r;
  logic [SUM_WIDTH:0] drem_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0] resid_r, mean_r;
  logic sat_r;
  logic out_tvalid_r;
  logic [5*W-1:0] out_data_r;

  // shared multiplier
  logic signed [W:0] ma, mb;
  logic signed [2*W+1:0] mp;
  assign mp = ma * mb;

  logic signed [W-1:0] in_coef;
  logic [3:0] in_idx;
  assign in_idx  = in_tdata[4:1];
  assign in_coef = in_tdata[5 +: W];

  logic signed [W+1:0] diff;
  assign diff = {{2{res_r[row_r][W-1]}}, res_r[row_r]} - {{2{refp_r[row_r][W-1]}}, refp_r[row_r]};
  logic [W:0] adiff;
  assign adiff = diff[W+1] ? (W+1)'(0) - diff[W:0] : diff[W:0];

  always_comb begin
    ma = '0; mb = '0;
    if (state_r == ST_MUL) begin
      ma = {coef_r[{2'b00, row_r}*4'd3 + {2'b00, col_r}][W-1], coef_r[{2'b00, row_r}*4'd3 + {2'b00, col_r}]};
      mb = {src_r[col_r][W-1], src_r[col_r]};
    end else begin
      ma = $signed(adiff); mb = $signed(adiff);
    end
  end

  // row rounding: sum of products rounded, plus translation, saturated
  logic signed [PW+2:0] rnd;
  logic signed [PW+2:0] rsum;
  logic signed [W-1:0] rsat;
  always_comb begin
    rnd  = (acc_r + (PW+3)'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
    rsum = rnd + (PW+3)'(coef_r[4'd9 + {2'b00, row_r}]);
    if (rsum > (PW+3)'(signed'({1'b0, {(W-1){1'b1}}})))
      rsat = {1'b0, {(W-1){1'b1}}};
    else if (rsum < -(PW+3)'(signed'({1'b0, {(W-1){1'b1}}})) - 1)
      rsat = {1'b1, {(W-1){1'b0}}};
    else
      rsat = rsum[W-1:0];
  end

  // square root step: two bits of radicand per cycle
  logic [SQW-1:0] trial;
  logic [SQW-1:0] rem_sh;
  logic sq_bit;
  logic [W-1:0] root_step;
  assign rem_sh    = {rem_r[SQW-3:0], sqs_r[SQW-1 -: 2]};
  assign trial     = {{(SQW-W-2){1'b0}}, root_r, 2'b01};
  assign sq_bit    = (rem_sh >= trial);
  assign root_step = {root_r[W-2:0], sq_bit};

  // division step: one quotient bit per cycle
  logic [SUM_WIDTH:0] dsh;
  logic div_ge;
  logic [SUM_WIDTH-1:0] quo_step;
  assign dsh      = {drem_r[SUM_WIDTH-1:0], quo_r[SUM_WIDTH-1]};
  assign div_ge   = (dsh >= (SUM_WIDTH+1)'(cnt_r));
  assign quo_step = {quo_r[SUM_WIDTH-2:0], div_ge};

  logic [SUM_WIDTH:0] sum_add;
  logic [CW-1:0] cnt_new;
  logic [SUM_WIDTH-1:0] sum_new;
  always_comb begin
    sum_add = {1'b0, sum_r} + (SUM_WIDTH+1)'(resid_r);
    sum_new = sum_r; cnt_new = cnt_r;
    if (cnt_r < CW'(MAX_POINTS)) begin
      sum_new = sum_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_add[SUM_WIDTH-1:0];
      cnt_new = cnt_r + 1'b1;
    end
  end

  // The finished pair moves into the output register once that register is free.
  logic out_load;
  assign out_load = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid && in_tdata[0] == OP_PAIR) state_nxt = ST_MUL;
      ST_MUL:  if (col_r == 2'd2) state_nxt = ST_ROW;
      ST_ROW:  state_nxt = (row_r == 2'd2) ? ST_SQ : ST_MUL;
      ST_SQ:   if (row_r == 2'd2) state_nxt = ST_SQRT;
      ST_SQRT: if (it_r == IW'(RW-1)) state_nxt = last_r ? ST_DIV : ST_OUT;
      ST_DIV:  if (it_r == IW'(SUM_WIDTH)) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < NUM_COEFS; i++) coef_r[i] <= '0;
      sum_r <= '0; cnt_r <= '0; out_tuser <= '0; out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_tvalid) begin
          if (in_tdata[0] == OP_LOAD) begin
            if (in_idx < 4'(NUM_COEFS)) coef_r[in_idx] <= in_coef;
          end else begin
            for (int i = 0; i < 3; i++) begin
              src_r[i]  <= in_tdata[5 + W*(1+i) +: W];
              refp_r[i] <= in_tdata[5 + W*(4+i) +: W];
            end
            last_r <= in_tlast;
            row_r <= '0; col_r <= '0; acc_r <= '0; sat_r <= 1'b0;
          end
        end
        ST_MUL: begin
          acc_r <= acc_r + (PW+3)'(mp);
          col_r <= col_r + 1'b1;
        end
        ST_ROW: begin
          res_r[row_r] <= rsat;
          acc_r <= '0; col_r <= '0;
          row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 1'b1;
          sqs_r <= '0;
        end
        ST_SQ: begin
          // squares of up to W+1 bits; a total of 2^PW or more saturates
          if ({1'b0, sqs_r} + (SQW+1)'(mp) >= (SQW+1)'(1) << PW) sat_r <= 1'b1;
          sqs_r <= sqs_r + SQW'(mp);
          row_r <= row_r + 1'b1;
          rem_r <= '0; root_r <= '0; it_r <= '0;
        end
        ST_SQRT: begin
          sqs_r <= {sqs_r[SQW-3:0], 2'b00};
          rem_r <= sq_bit ? rem_sh - trial : rem_sh;
          root_r <= root_step;
          if (it_r == IW'(RW-1)) begin
            resid_r <= sat_r ? {W{1'b1}} : root_step;
            mean_r <= '0;
            it_r <= '0;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        ST_DIV: begin
          it_r <= it_r + 1'b1;
          if (it_r == '0) begin
            quo_r <= sum_new; drem_r <= '0;
            sum_r <= sum_new; cnt_r <= cnt_new;
          end else begin
            quo_r <= quo_step;
            drem_r <= div_ge ? dsh - (SUM_WIDTH+1)'(cnt_r) : dsh;
            if (it_r == IW'(SUM_WIDTH)) begin
              // The mean saturates to the coordinate width; the set then starts over.
              mean_r <= (quo_step > SUM_WIDTH'({W{1'b1}})) ? {W{1'b1}} : quo_step[W-1:0];
              sum_r <= '0; cnt_r <= '0;
            end
          end
        end
        ST_OUT: if (out_load) begin
          out_data_r <= {mean_r, resid_r, res_r[2], res_r[1], res_r[0]};
          out_tuser <= last_r;
          if (!last_r) begin
            sum_r <= sum_new; cnt_r <= cnt_new;
          end
        end
        default: ;
      endcase
    end
  end

  // A waiting output request keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser));
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r));
  a_mean_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[5*W-1:4*W] == '0);
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS));
endmodule
`default_nettype wire
